### rtl/core/dlpe_pkg.sv
package dlpe_pkg;

   // default width of the pulse duration fields
   localparam int DLPE_DURATION_BITS = 15;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BRIGHTNESS    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_HIGH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ZERO_LOW      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ONE_HIGH      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ONE_LOW       = 3'd4;

   // brightness register
   localparam int PERCENT_BITS = 7;
   localparam logic [PERCENT_BITS-1:0] PERCENT_FULL = 7'd100;

   // timing register reset values
   localparam int ZERO_HIGH_RESET = 14;
   localparam int ZERO_LOW_RESET  = 32;
   localparam int ONE_HIGH_RESET  = 28;
   localparam int ONE_LOW_RESET   = 24;

   // colour byte and pulse count
   localparam int BYTE_BITS  = 8;
   localparam int COUNT_BITS = 3;
   localparam logic [COUNT_BITS-1:0] LAST_PULSE = 3'd7;

   // divide by 100 as multiply by 5243 and shift by 19, exact for products up to 25500
   localparam int PRODUCT_BITS = BYTE_BITS + PERCENT_BITS;
   localparam int RECIP_BITS   = 13;
   localparam logic [RECIP_BITS-1:0] RECIP_100 = 13'd5243;
   localparam int RECIP_SHIFT  = 19;
   localparam int QUOT_BITS    = PRODUCT_BITS + RECIP_BITS;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [BYTE_BITS-1:0] scaled_byte;
      logic                 frame_end;
   } queue_entry_type;

endpackage

### rtl/core/dlpe_if.sv
interface dlpe_req_if
   import dlpe_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] color_byte;
   logic                 frame_end;

   modport source (output valid, output color_byte, output frame_end, input ready);
   modport sink (input valid, input color_byte, input frame_end, output ready);
endinterface

interface dlpe_rsp_if
   import dlpe_pkg::*;
#(
   parameter int DURATION_BITS = DLPE_DURATION_BITS
);
   logic                     valid;
   logic                     ready;
   logic [DURATION_BITS-1:0] high_ticks;
   logic [DURATION_BITS-1:0] low_ticks;
   logic                     byte_last;
   logic                     frame_last;

   modport source (
      output valid, output high_ticks, output low_ticks, output byte_last,
      output frame_last, input ready
   );
   modport sink (
      input valid, input high_ticks, input low_ticks, input byte_last,
      input frame_last, output ready
   );
endinterface

### rtl/core/dimmed_led_pulse_encoder.sv
// the first pulse descriptor of a byte passes the stage-one register, the queue and the output register
// eight descriptors per byte, one per cycle while the receiver is ready,
//    from the single output register of the serialiser
// a two-entry queue lets the front take the next byte while the serialiser works
// reset (synchronous, active high) empties the pipeline and queue and loads
//    brightness 100 and the default zero and one bit timings
module dimmed_led_pulse_encoder
   import dlpe_pkg::*;
#(
   parameter int DURATION_BITS = DLPE_DURATION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   dlpe_req_if.sink                  req,
   dlpe_rsp_if.source                rsp,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DURATION_BITS-1:0]  csr_write_data
);

   logic [PERCENT_BITS-1:0]  brightness_ff;
   logic [DURATION_BITS-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff;
   logic [PERCENT_BITS-1:0]  percent_value;

   logic            push, pop, queue_full, queue_empty;
   queue_entry_type push_entry, head;

   // configuration registers
   assign percent_value = csr_write_data[PERCENT_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= PERCENT_FULL;
         zero_high_ff  <= DURATION_BITS'(ZERO_HIGH_RESET);
         zero_low_ff   <= DURATION_BITS'(ZERO_LOW_RESET);
         one_high_ff   <= DURATION_BITS'(ONE_HIGH_RESET);
         one_low_ff    <= DURATION_BITS'(ONE_LOW_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BRIGHTNESS: begin
               if (percent_value <= PERCENT_FULL) begin
                  brightness_ff <= percent_value;
               end
            end
            CSR_ZERO_HIGH: zero_high_ff <= csr_write_data;
            CSR_ZERO_LOW:  zero_low_ff  <= csr_write_data;
            CSR_ONE_HIGH:  one_high_ff  <= csr_write_data;
            CSR_ONE_LOW:   one_low_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // scaling front
   dlpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req.valid),
      .in_ready   (req.ready),
      .color_byte (req.color_byte),
      .frame_end  (req.frame_end),
      .brightness (brightness_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // scaled byte queue
   dlpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .empty      (queue_empty),
      .head       (head)
   );

   // pulse serialiser
   dlpe_back #(
      .DURATION_BITS (DURATION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head        (head),
      .pop         (pop),
      .zero_high   (zero_high_ff),
      .zero_low    (zero_low_ff),
      .one_high    (one_high_ff),
      .one_low     (one_low_ff),
      .out_valid   (rsp.valid),
      .out_ready   (rsp.ready),
      .high_ticks  (rsp.high_ticks),
      .low_ticks   (rsp.low_ticks),
      .byte_last   (rsp.byte_last),
      .frame_last  (rsp.frame_last)
   );

endmodule

### rtl/core/dlpe_front.sv
module dlpe_front
   import dlpe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [BYTE_BITS-1:0]    color_byte,
   input  logic                    frame_end,
   input  logic [PERCENT_BITS-1:0] brightness,
   input  logic                    queue_full,
   output logic                    push,
   output queue_entry_type         push_entry
);

   logic                    s1_valid_ff, s1_valid_in;
   logic [PRODUCT_BITS-1:0] s1_prod_ff;
   logic                    s1_flag_ff;
   logic                    accept;
   logic [QUOT_BITS-1:0]    quot_full;

   // stage one holds the product until the queue has room
   assign in_ready = !s1_valid_ff || !queue_full;
   assign accept   = in_valid && in_ready;
   assign push     = s1_valid_ff && !queue_full;

   always_comb begin
      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // byte times percent
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff <= PRODUCT_BITS'(color_byte) * PRODUCT_BITS'(brightness);
         s1_flag_ff <= frame_end;
      end
   end

   // divide by one hundred through the reciprocal
   assign quot_full = QUOT_BITS'(s1_prod_ff) * QUOT_BITS'(RECIP_100);
   assign push_entry.scaled_byte = quot_full[RECIP_SHIFT +: BYTE_BITS];
   assign push_entry.frame_end   = s1_flag_ff;

   a_push_needs_stage : assert property (@(posedge clock) disable iff (reset)
      push |-> s1_valid_ff)
      else $error("push without a held product");

endmodule

### rtl/core/dlpe_queue.sv
module dlpe_queue
   import dlpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  queue_entry_type push_entry,
   input  logic            pop,
   output logic            full,
   output logic            empty,
   output queue_entry_type head
);

   queue_entry_type           entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

### rtl/core/dlpe_back.sv
module dlpe_back
   import dlpe_pkg::*;
#(
   parameter int DURATION_BITS = DLPE_DURATION_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  queue_entry_type          head,
   output logic                     pop,
   input  logic [DURATION_BITS-1:0] zero_high,
   input  logic [DURATION_BITS-1:0] zero_low,
   input  logic [DURATION_BITS-1:0] one_high,
   input  logic [DURATION_BITS-1:0] one_low,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [DURATION_BITS-1:0] high_ticks,
   output logic [DURATION_BITS-1:0] low_ticks,
   output logic                     byte_last,
   output logic                     frame_last
);

   logic                     active_ff;
   logic [BYTE_BITS-1:0]     shift_ff;
   logic [COUNT_BITS-1:0]    count_ff;
   logic                     flag_ff;
   logic                     out_valid_ff, out_valid_in;
   logic [DURATION_BITS-1:0] high_ff, low_ff;
   logic                     byte_last_ff, frame_last_ff;

   logic [BYTE_BITS-1:0]     cur_byte;
   logic [COUNT_BITS-1:0]    cur_count;
   logic                     cur_flag;
   logic                     have_bit;
   logic                     emit;
   logic                     cur_last;

   // current bit comes from the held byte or straight from the queue head
   assign cur_byte  = active_ff ? shift_ff : head.scaled_byte;
   assign cur_count = active_ff ? count_ff : '0;
   assign cur_flag  = active_ff ? flag_ff : head.frame_end;
   assign have_bit  = active_ff || !queue_empty;
   assign emit      = have_bit && (!out_valid_ff || out_ready);
   assign pop       = emit && !active_ff;
   assign cur_last  = (cur_count == LAST_PULSE);

   // serialiser state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (emit) begin
         active_ff <= !cur_last;
         count_ff  <= cur_count + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         shift_ff <= {cur_byte[BYTE_BITS-2:0], 1'b0};
         flag_ff  <= cur_flag;
      end
   end

   // output register
   assign out_valid_in = emit || (out_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         high_ff       <= cur_byte[BYTE_BITS-1] ? one_high : zero_high;
         low_ff        <= cur_byte[BYTE_BITS-1] ? one_low : zero_low;
         byte_last_ff  <= cur_last;
         frame_last_ff <= cur_last && cur_flag;
      end
   end

   assign out_valid  = out_valid_ff;
   assign high_ticks = high_ff;
   assign low_ticks  = low_ff;
   assign byte_last  = byte_last_ff;
   assign frame_last = frame_last_ff;

   a_frame_mark_on_byte_end : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && frame_last_ff) |-> byte_last_ff)
      else $error("frame mark without byte mark");

   a_active_count : assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (count_ff != '0))
      else $error("active with pulse count at zero");

   a_byte_done : assert property (@(posedge clock) disable iff (reset)
      (emit && active_ff && count_ff == LAST_PULSE) |=> !active_ff)
      else $error("serialiser still active after eighth pulse");

endmodule

### tb/dlpe_pulse_checker.sv
`timescale 1ns / 1ps

module dlpe_pulse_checker
   import dlpe_pkg::*;
#(
   parameter int DURATION_BITS = DLPE_DURATION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [BYTE_BITS-1:0]      req_color_byte,
   input  logic                      req_frame_end,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [DURATION_BITS-1:0]  rsp_high_ticks,
   input  logic [DURATION_BITS-1:0]  rsp_low_ticks,
   input  logic                      rsp_byte_last,
   input  logic                      rsp_frame_last,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [DURATION_BITS-1:0]  csr_write_data,
   output int                        mismatch_count,
   output int                        pending_pulses,
   output int                        bytes_seen,
   output int                        pulses_seen
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [DURATION_BITS-1:0] high_ticks;
      logic [DURATION_BITS-1:0] low_ticks;
      logic                     byte_last;
      logic                     frame_last;
   } pulse_type;

   // pulses still owed by the block, oldest first
   pulse_type expected_pulses[$];

   // shadow copy of the configuration registers
   logic [PERCENT_BITS-1:0]  percent;
   logic [DURATION_BITS-1:0] zero_high;
   logic [DURATION_BITS-1:0] zero_low;
   logic [DURATION_BITS-1:0] one_high;
   logic [DURATION_BITS-1:0] one_low;

   initial begin
      mismatch_count = 0;
      pending_pulses = 0;
      bytes_seen     = 0;
      pulses_seen    = 0;
   end

   // scale the byte, then queue its eight pulses msb first
   function automatic void predict_byte_pulses(input logic [BYTE_BITS-1:0] color,
                                               input logic frame_end);
      int unsigned          scaled_wide;
      logic [BYTE_BITS-1:0] scaled;
      pulse_type            pulse;
      int                   k;
      scaled_wide = (int'(color) * int'(percent)) / int'(PERCENT_FULL);
      scaled = scaled_wide[BYTE_BITS-1:0];
      for (k = BYTE_BITS - 1; k >= 0; k--) begin
         pulse.high_ticks = scaled[k] ? one_high : zero_high;
         pulse.low_ticks  = scaled[k] ? one_low : zero_low;
         pulse.byte_last  = (k == 0);
         pulse.frame_last = (k == 0) && frame_end;
         expected_pulses.push_back(pulse);
      end
   endfunction

   function automatic void flag_mismatch(input string why, input pulse_type want,
                                         input pulse_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t pulse %0d %s: expected high %0d low %0d byte_last %0b frame_last %0b",
                  $time, pulses_seen, why, want.high_ticks, want.low_ticks,
                  want.byte_last, want.frame_last);
         $display("   got high %0d low %0d byte_last %0b frame_last %0b",
                  got.high_ticks, got.low_ticks, got.byte_last, got.frame_last);
      end
   endfunction

   always @(posedge clock) begin
      pulse_type got;
      pulse_type want;
      if (reset) begin
         percent   = PERCENT_FULL;
         zero_high = DURATION_BITS'(ZERO_HIGH_RESET);
         zero_low  = DURATION_BITS'(ZERO_LOW_RESET);
         one_high  = DURATION_BITS'(ONE_HIGH_RESET);
         one_low   = DURATION_BITS'(ONE_LOW_RESET);
         expected_pulses.delete();
      end else begin
         // result transfer against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_high_ticks, rsp_low_ticks, rsp_byte_last, rsp_frame_last};
            pulses_seen++;
            if (expected_pulses.size() == 0) begin
               flag_mismatch("with nothing expected", '0, got);
            end else begin
               want = expected_pulses.pop_front();
               if (got !== want)
                  flag_mismatch("wrong", want, got);
            end
         end

         // register writes; brightness above full scale is dropped
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BRIGHTNESS: begin
                  if (csr_write_data[PERCENT_BITS-1:0] <= PERCENT_FULL)
                     percent = csr_write_data[PERCENT_BITS-1:0];
               end
               CSR_ZERO_HIGH: zero_high = csr_write_data;
               CSR_ZERO_LOW:  zero_low  = csr_write_data;
               CSR_ONE_HIGH:  one_high  = csr_write_data;
               CSR_ONE_LOW:   one_low   = csr_write_data;
               default: ;
            endcase
         end

         // colour byte transfer
         if (req_valid && req_ready) begin
            bytes_seen++;
            predict_byte_pulses(req_color_byte, req_frame_end);
         end
      end
      pending_pulses = expected_pulses.size();
   end

endmodule

### tb/dimmed_led_pulse_encoder_tb.sv
`timescale 1ns / 1ps

module dimmed_led_pulse_encoder_tb;
   import dlpe_pkg::*;

   localparam int DUR_BITS         = DLPE_DURATION_BITS;
   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 250000;
   localparam int RANDOM_SEGMENTS  = 4;
   localparam int SEGMENT_BYTES    = 55;

   logic                      clock;
   logic                      reset;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DUR_BITS-1:0]       csr_write_data;

   int mismatch_count;
   int pending_pulses;
   int bytes_seen;
   int pulses_seen;
   int cycle_count;
   int burst_left;
   int reg_writes;
   int settings_used;
   bit long_hold_req;
   bit long_hold_done;

   dlpe_req_if                             req_bus ();
   dlpe_rsp_if #(.DURATION_BITS(DUR_BITS)) rsp_bus ();

   dimmed_led_pulse_encoder #(.DURATION_BITS(DUR_BITS)) u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_bus),
      .rsp              (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   dlpe_pulse_checker #(.DURATION_BITS(DUR_BITS)) u_pulse_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_bus.valid),
      .req_ready        (req_bus.ready),
      .req_color_byte   (req_bus.color_byte),
      .req_frame_end    (req_bus.frame_end),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_high_ticks   (rsp_bus.high_ticks),
      .rsp_low_ticks    (rsp_bus.low_ticks),
      .rsp_byte_last    (rsp_bus.byte_last),
      .rsp_frame_last   (rsp_bus.frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_pulses   (pending_pulses),
      .bytes_seen       (bytes_seen),
      .pulses_seen      (pulses_seen)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles with %0d pulses outstanding",
               cycle_count, pending_pulses);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random stretches of ready patterns, one long hold on request
   initial begin
      int stretch;
      int mode;
      int held;
      rsp_bus.ready = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_bus.ready <= 1'b0;
            held = 0;
            while (held < LONG_HOLD_CYCLES) begin
               @(negedge clock);
               held++;
            end
            long_hold_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(1, 40);
            repeat (stretch) begin
               case (mode)
                  0: rsp_bus.ready <= 1'b1;
                  1: rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_bus.ready <= ~rsp_bus.ready;
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // one colour byte transfer, sender sometimes idles between bursts
   task automatic send_byte(input logic [BYTE_BITS-1:0] color, input logic frame_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.color_byte <= color;
      req_bus.frame_end  <= frame_end;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [DUR_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      reg_writes++;
   endtask

   // stop offering and wait until every pulse is back
   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_pulses != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      settings_used++;
   endtask

   function automatic logic [DUR_BITS-1:0] random_ticks();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return DUR_BITS'($urandom());
      endcase
   endfunction

   function automatic logic [BYTE_BITS-1:0] random_component();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return BYTE_BITS'($urandom());
      endcase
   endfunction

   // fresh brightness and timings, sometimes a rejected or wide value or a write to an unused index
   task automatic reconfigure_random();
      logic [DUR_BITS-1:0] value;
      int                  r;
      case ($urandom_range(0, 5))
         0: value = '0;
         1: value = DUR_BITS'(PERCENT_FULL);
         2: value = DUR_BITS'($urandom_range(int'(PERCENT_FULL) + 1, 2**PERCENT_BITS - 1));
         3: value = DUR_BITS'($urandom());
         default: value = DUR_BITS'($urandom_range(0, int'(PERCENT_FULL)));
      endcase
      write_reg(CSR_BRIGHTNESS, value);
      for (r = int'(CSR_ZERO_HIGH); r <= int'(CSR_ONE_LOW); r++)
         write_reg(CSR_INDEX_BITS'(r), random_ticks());
      if ($urandom_range(0, 2) == 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(int'(CSR_ONE_LOW) + 1,
                                                  2**CSR_INDEX_BITS - 1)),
                   DUR_BITS'($urandom()));
   endtask

   // mostly whole frames of three-byte pixels, some loose bytes with random end flags
   task automatic run_random_segment(input int target);
      int sent;
      int n;
      int i;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(0, 9) < 8) begin
            n = 3 * $urandom_range(1, 5);
            for (i = 0; i < n; i++)
               send_byte(random_component(), i == n - 1);
         end else begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
               send_byte(BYTE_BITS'($urandom()), 1'($urandom_range(0, 1)));
         end
         sent += n;
      end
      finish_phase();
   endtask

   // stimulus and verdict
   initial begin
      int s;
      int idx;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.color_byte = '0;
      req_bus.frame_end  = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_BRIGHTNESS;
      csr_write_data     = '0;
      burst_left         = 0;
      reg_writes         = 0;
      settings_used      = 0;
      long_hold_req      = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset defaults
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      finish_phase();

      // zero brightness gives only zero bits; zero and full-scale durations
      write_reg(CSR_BRIGHTNESS, '0);
      write_reg(CSR_ZERO_HIGH, '0);
      write_reg(CSR_ZERO_LOW, '1);
      write_reg(CSR_ONE_HIGH, '1);
      write_reg(CSR_ONE_LOW, '0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      finish_phase();

      // lowest brightness, then values above full scale that must be dropped
      write_reg(CSR_BRIGHTNESS, DUR_BITS'(1));
      write_reg(CSR_BRIGHTNESS, DUR_BITS'(int'(PERCENT_FULL) + 1));
      write_reg(CSR_BRIGHTNESS, DUR_BITS'(2**PERCENT_BITS - 1));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h64, 1'b1);
      finish_phase();

      // half scale with the timings mirrored
      write_reg(CSR_BRIGHTNESS, DUR_BITS'(50));
      write_reg(CSR_ZERO_HIGH, '1);
      write_reg(CSR_ZERO_LOW, '0);
      write_reg(CSR_ONE_HIGH, '0);
      write_reg(CSR_ONE_LOW, '1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'hC8, 1'b1);
      finish_phase();

      // wide brightness value keeps only its low bits; unused indexes are inert
      write_reg(CSR_BRIGHTNESS, 15'h7F85);
      for (idx = int'(CSR_ONE_LOW) + 1; idx < 2**CSR_INDEX_BITS; idx++)
         write_reg(CSR_INDEX_BITS'(idx), DUR_BITS'($urandom()));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h14, 1'b1);
      finish_phase();

      // back to full scale and default timings
      write_reg(CSR_BRIGHTNESS, DUR_BITS'(PERCENT_FULL));
      write_reg(CSR_ZERO_HIGH, DUR_BITS'(ZERO_HIGH_RESET));
      write_reg(CSR_ZERO_LOW, DUR_BITS'(ZERO_LOW_RESET));
      write_reg(CSR_ONE_HIGH, DUR_BITS'(ONE_HIGH_RESET));
      write_reg(CSR_ONE_LOW, DUR_BITS'(ONE_LOW_RESET));
      send_byte(8'hFF, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFE, 1'b1);
      send_byte(8'h00, 1'b1);
      finish_phase();

      // random frames; the first segment runs into a long receiver hold
      for (s = 0; s < RANDOM_SEGMENTS; s++) begin
         reconfigure_random();
         if (s == 0)
            long_hold_req = 1'b1;
         run_random_segment(SEGMENT_BYTES);
      end

      $display("covered %0d colour bytes and %0d pulse descriptors in %0d settings",
               bytes_seen, pulses_seen, settings_used);
      $display("with %0d register writes and a %0d-cycle receiver hold",
               reg_writes, LONG_HOLD_CYCLES);
      if (mismatch_count == 0 && pending_pulses == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
